// File: design/clle_pkg.sv
package clle_pkg;

    // field widths of one item and one result
    localparam int POS_W = 10;
    localparam int VAL_W = 8;
    localparam int LEN_W = 10;

    // operation codes
    localparam logic [1:0] OP_INS = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_RD  = 2'd2;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic             status;
        logic [VAL_W-1:0] read_value;
        logic [LEN_W-1:0] length;
    } t_result;

endpackage

// File: design/cursor_linked_list_engine_top.sv
// Channel   Direction  Handshake             Payload
// command   in         start && !busy        i_cmd    (opcode, position, value)
// result    out        o_done, one cycle     o_result (status, read_value, length)
//
// An item walks the link memory from the head slot, one hop per cycle on the
// link RAM read port, then passes S_INS (insert), S_RD (read) or S_DEL_A and
// S_DEL_B (delete) with busy high; a rejected item never raises busy.
// The result strobe is registered and rises at the edge on which busy falls.
// After reset a clearing pass writes the link of every slot to build the free
// chain, with busy high. The result cannot be stalled; busy is the only back pressure.
module cursor_linked_list_engine_top #(
    parameter int DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  clle_pkg::t_cmd    i_cmd,
    output logic              busy,
    output logic              o_done,
    output clle_pkg::t_result o_result
);
    import clle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam logic [AW-1:0] HEAD_SLOT = AW'(DEPTH - 1);
    localparam logic [AW-1:0] LAST_FREE = AW'(DEPTH - 2);
    localparam logic [AW-1:0] NIL       = '0;
    localparam logic [AW-1:0] MAX_CNT   = AW'(DEPTH - 2);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_WALK  = 7'b0000100,
        S_INS   = 7'b0001000,
        S_DEL_A = 7'b0010000,
        S_DEL_B = 7'b0100000,
        S_RD    = 7'b1000000
    } t_state;

    // control state
    t_state     r_state, n_state;
    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_free_head, n_free_head;
    logic [AW-1:0] r_clr, n_clr;
    logic       r_done, n_done;

    // item context
    logic [1:0]       r_op, n_op;
    logic [VAL_W-1:0] r_val, n_val;
    logic [POS_W-1:0] r_hops, n_hops;
    logic [AW-1:0]    r_prev, n_prev;
    logic [AW-1:0]    r_nxt, n_nxt;
    logic [AW-1:0]    r_tmp, n_tmp;
    t_result          r_res, n_res;

    // memory ports
    logic             lk_we;
    logic [AW-1:0]    lk_waddr, lk_wdata, lk_raddr, lk_rdata;
    logic             by_we;
    logic [AW-1:0]    by_waddr, by_raddr;
    logic [VAL_W-1:0] by_wdata, by_rdata;

    // position checks
    logic [CW-1:0] pos_c, cnt_c;
    logic          rng_ok, ins_ok, cmd_ok, accept;

    clle_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    clle_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (by_we),
        .i_waddr (by_waddr),
        .i_wdata (by_wdata),
        .i_raddr (by_raddr),
        .o_rdata (by_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // range checks of the incoming item
    always_comb begin
        pos_c  = CW'(i_cmd.position);
        cnt_c  = CW'(r_count);
        rng_ok = (i_cmd.position != '0) && (pos_c <= cnt_c);
        ins_ok = (i_cmd.position != '0) && (pos_c <= cnt_c + CW'(1)) && (r_free_head != NIL);
        if (i_cmd.opcode == OP_INS) begin
            cmd_ok = ins_ok;
        end else if (i_cmd.opcode inside {OP_DEL, OP_RD}) begin
            cmd_ok = rng_ok;
        end else begin
            cmd_ok = 1'b0;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_free_head = r_free_head;
        n_clr       = r_clr;
        n_done      = 1'b0;
        n_op        = r_op;
        n_val       = r_val;
        n_hops      = r_hops;
        n_prev      = r_prev;
        n_nxt       = r_nxt;
        n_tmp       = r_tmp;
        n_res       = r_res;
        lk_we       = 1'b0;
        lk_waddr    = r_prev;
        lk_wdata    = r_nxt;
        lk_raddr    = HEAD_SLOT;
        by_we       = 1'b0;
        by_waddr    = r_free_head;
        by_wdata    = r_val;
        by_raddr    = lk_rdata;

        case (r_state)
            S_CLEAR: begin
                // slot k links to k+1; the last free slot and the head end in nil
                lk_we    = 1'b1;
                lk_waddr = r_clr;
                lk_wdata = (r_clr < LAST_FREE) ? (r_clr + AW'(1)) : NIL;
                n_clr    = r_clr + AW'(1);
                if (r_clr == HEAD_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (cmd_ok) begin
                        // first hop: read the head link
                        lk_raddr = HEAD_SLOT;
                        n_prev   = HEAD_SLOT;
                        n_hops   = i_cmd.position - POS_W'(1);
                        n_op     = i_cmd.opcode;
                        n_val    = i_cmd.value;
                        n_state  = S_WALK;
                    end else begin
                        n_done           = 1'b1;
                        n_res.status     = ST_ERR;
                        n_res.read_value = '0;
                        n_res.length     = LEN_W'(r_count);
                    end
                end
            end
            S_WALK: begin
                if (r_hops != '0) begin
                    // one hop per cycle
                    lk_raddr = lk_rdata;
                    n_prev   = lk_rdata;
                    n_hops   = r_hops - POS_W'(1);
                end else begin
                    n_nxt = lk_rdata;
                    if (r_op == OP_INS) begin
                        // link prev to the free slot, store the byte, fetch free next
                        lk_we    = 1'b1;
                        lk_waddr = r_prev;
                        lk_wdata = r_free_head;
                        by_we    = 1'b1;
                        lk_raddr = r_free_head;
                        n_state  = S_INS;
                    end else if (r_op == OP_DEL) begin
                        lk_raddr = lk_rdata;
                        n_state  = S_DEL_A;
                    end else begin
                        by_raddr = lk_rdata;
                        n_state  = S_RD;
                    end
                end
            end
            S_INS: begin
                lk_we            = 1'b1;
                lk_waddr         = r_free_head;
                lk_wdata         = r_nxt;
                n_free_head      = lk_rdata;
                n_count          = r_count + AW'(1);
                n_done           = 1'b1;
                n_res.status     = ST_OK;
                n_res.read_value = '0;
                n_res.length     = LEN_W'(n_count);
                n_state          = S_IDLE;
            end
            S_DEL_A: begin
                // unlink the victim and push it on the free chain
                lk_we       = 1'b1;
                lk_waddr    = r_prev;
                lk_wdata    = lk_rdata;
                n_tmp       = r_free_head;
                n_free_head = r_nxt;
                n_count     = r_count - AW'(1);
                n_state     = S_DEL_B;
            end
            S_DEL_B: begin
                lk_we            = 1'b1;
                lk_waddr         = r_nxt;
                lk_wdata         = r_tmp;
                n_done           = 1'b1;
                n_res.status     = ST_OK;
                n_res.read_value = '0;
                n_res.length     = LEN_W'(r_count);
                n_state          = S_IDLE;
            end
            S_RD: begin
                n_done           = 1'b1;
                n_res.status     = ST_OK;
                n_res.read_value = by_rdata;
                n_res.length     = LEN_W'(r_count);
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_free_head <= AW'(1);
            r_clr       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_free_head <= n_free_head;
            r_clr       <= n_clr;
            r_done      <= n_done;
        end
    end

    // item context registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_val  <= n_val;
        r_hops <= n_hops;
        r_prev <= n_prev;
        r_nxt  <= n_nxt;
        r_tmp  <= n_tmp;
        r_res  <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // list never outgrows the store
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("element count above capacity");

    // free chain is empty exactly when the list is full
    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> ((r_free_head == NIL) == (r_count == MAX_CNT)))
        else $error("free chain and element count disagree");

    // a rejected item answers with an error on the next cycle
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !cmd_ok) |=> (o_done && (o_result.status == ST_ERR)))
        else $error("rejected item without error result");

    // delete and read always land on a list element
    a_walk_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_hops == '0 && r_op != OP_INS) |-> (lk_rdata != NIL))
        else $error("walk ran off the end of the list");

endmodule

// File: design/clle_ram.sv
module clle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
